// ----- rtl/core/swms_pkg.sv -----
// swms_pkg: shared widths, limits and register indexes for the sliding window mode block
// no dependencies; imported by sliding_window_mode_sum_top
`default_nettype none

package swms_pkg;

    // fixed field widths of the item and result ports
    localparam int SAMPLE_W = 8;
    localparam int WS_W     = 7;
    localparam int COUNT_W  = 7;
    localparam int MODE_W   = 8;
    localparam int SUM_W    = 48;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register indexes
    localparam logic REG_WINDOW_SIZE = 1'b0;

    // count saturation limit
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // window size after reset
    localparam logic [WS_W-1:0] WS_RESET = WS_W'(1);

endpackage : swms_pkg

`default_nettype wire

// ----- rtl/core/swms_ram.sv -----
// swms_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies; used for the sample ring and the count table
`default_nettype none

module swms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : swms_ram

`default_nettype wire

// ----- rtl/core/sliding_window_mode_sum_top.sv -----
// sliding_window_mode_sum_top: sliding window mode with a saturating running sum of modes
// depends on swms_pkg and swms_ram (sample ring and count table)
`default_nettype none

// Takes one unsigned sample per item and keeps the last window_size samples in a
// ring memory next to a count table with one entry per sample value. Every item
// gives one result: once the window is full, the mode (smallest value on ties),
// its count and the saturating sum of all modes so far; before that, zeros and
// the current sum. start_req, or any write to window_size, begins a new sequence.
// An item that finds the window already full goes through S_RING, S_OLDA and
// S_OLDB to drop the oldest sample and S_NEWA and S_NEWB to add the new one
// through the single read port of the count table, then S_SCAN scans the table
// one entry per cycle, S_OUT loads the result and the sequencer returns to
// S_IDLE. The item that first fills the window skips the removal; an item that
// leaves the window short of full skips the scan as well. The count table is
// cleared at once through a valid bit per entry, so there is no clearing pass
// after reset. The next item is accepted while a finished result still waits in
// the output register; the result after it then waits in the sequencer, and
// holds off the input, until the first one is taken.

module sliding_window_mode_sum_top
    import swms_pkg::*;
#(
    parameter int WINDOW_MAX = 64,
    parameter int VALUE_BITS = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // item channel
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic                start_req,
    // result channel
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     window_full,
    output logic [MODE_W-1:0]        mode_value,
    output logic [COUNT_W-1:0]       mode_count,
    output logic [SUM_W-1:0]         running_sum,
    // configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    localparam int NV   = 2 ** VALUE_BITS;
    localparam int VB   = VALUE_BITS;
    localparam int RA   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FW   = $clog2(WINDOW_MAX + 1);
    localparam int AW   = (FW > WS_W) ? FW : WS_W;
    localparam int SC_W = VB + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RING,
        S_OLDA,
        S_OLDB,
        S_NEWA,
        S_NEWB,
        S_SCAN,
        S_OUT
    } state_t;

    state_t             state_reg;
    logic [WS_W-1:0]    window_size_reg;
    logic [RA-1:0]      write_position_reg;
    logic [FW-1:0]      fill_level_reg;
    logic [SUM_W-1:0]   mode_total_reg;
    logic [NV-1:0]      cnt_valid_reg;
    logic [VB-1:0]      sample_reg;
    logic [RA-1:0]      pos_reg;
    logic [VB-1:0]      cnt_rd_idx_reg;
    logic [SC_W-1:0]    scan_cnt_reg;
    logic               scan_pend_reg;
    logic [VB-1:0]      best_val_reg;
    logic [COUNT_W-1:0] best_cnt_reg;
    logic               full_reg;

    logic               out_valid_reg;
    logic               window_full_reg;
    logic [MODE_W-1:0]  mode_value_reg;
    logic [COUNT_W-1:0] mode_count_reg;
    logic [SUM_W-1:0]   running_sum_reg;

    logic [AW-1:0]      ws_ext;
    logic [AW-1:0]      active_ext;
    logic [FW-1:0]      win;
    logic               cfg_wr;
    logic               in_acc;
    logic [VB-1:0]      s_in;
    logic [RA-1:0]      pos_start;
    logic [RA-1:0]      pos_eff;
    logic [FW-1:0]      fill_eff;
    logic [FW-1:0]      pos_inc;
    logic [RA-1:0]      pos_next;
    logic [FW-1:0]      fill_next;

    logic               ring_we;
    logic [VB-1:0]      ring_rdata;
    logic               cnt_we;
    logic [VB-1:0]      cnt_raddr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [COUNT_W-1:0] cnt_rdata;
    logic [COUNT_W-1:0] cnt_cur;

    logic [SUM_W:0]     sum_ext;
    logic [SUM_W-1:0]   sum_sat;
    logic               out_free;

    // sample ring
    swms_ram #(
        .WIDTH (VB),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .raddr (pos_reg),
        .rdata (ring_rdata)
    );

    // count table, one entry per sample value
    swms_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NV)
    ) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_rd_idx_reg),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // active window size, clamped to 1..WINDOW_MAX
    always_comb
    begin
        ws_ext = AW'(window_size_reg);
        if (ws_ext == '0)
        begin
            active_ext = AW'(1);
        end
        else if (ws_ext > AW'(WINDOW_MAX))
        begin
            active_ext = AW'(WINDOW_MAX);
        end
        else
        begin
            active_ext = ws_ext;
        end
        win = FW'(active_ext);
    end

    // handshakes
    assign cfg_wr   = psel & penable & pwrite & (paddr[2] == REG_WINDOW_SIZE);
    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid & in_ready;
    assign out_free = ~out_valid_reg | out_ready;
    assign pready   = 1'b1;

    // register read back
    assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? APB_DW'(window_size_reg) : '0;

    // ring position and fill for the item being accepted
    always_comb
    begin
        s_in      = VB'(sample);
        pos_start = start_req ? '0 : write_position_reg;
        pos_eff   = (FW'(pos_start) >= win) ? '0 : pos_start;
        fill_eff  = start_req ? '0 : fill_level_reg;
    end

    // ring position and fill after the sample enters
    always_comb
    begin
        pos_inc   = FW'(pos_reg) + FW'(1);
        pos_next  = (pos_inc >= win) ? '0 : RA'(pos_inc);
        fill_next = (fill_level_reg < win) ? (fill_level_reg + FW'(1)) : fill_level_reg;
    end

    // count table access; entries not yet valid read as zero
    always_comb
    begin
        cnt_cur   = cnt_valid_reg[cnt_rd_idx_reg] ? cnt_rdata : '0;
        ring_we   = (state_reg == S_NEWA);
        cnt_we    = 1'b0;
        cnt_wdata = cnt_cur;
        cnt_raddr = sample_reg;
        case (state_reg)
            S_OLDA:
            begin
                cnt_raddr = ring_rdata;
            end
            S_OLDB:
            begin
                cnt_we    = (cnt_cur != '0);
                cnt_wdata = cnt_cur - COUNT_W'(1);
            end
            S_NEWB:
            begin
                cnt_we    = 1'b1;
                cnt_wdata = (cnt_cur != COUNT_MAX) ? (cnt_cur + COUNT_W'(1)) : cnt_cur;
            end
            S_SCAN:
            begin
                cnt_raddr = scan_cnt_reg[VB-1:0];
            end
            default:
            begin
                cnt_raddr = sample_reg;
            end
        endcase
    end

    // saturating sum of modes
    always_comb
    begin
        sum_ext = {1'b0, mode_total_reg} + (SUM_W + 1)'(best_val_reg);
        sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    end

    // sequencer, state registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            window_size_reg    <= WS_RESET;
            write_position_reg <= '0;
            fill_level_reg     <= '0;
            mode_total_reg     <= '0;
            cnt_valid_reg      <= '0;
            sample_reg         <= '0;
            pos_reg            <= '0;
            cnt_rd_idx_reg     <= '0;
            scan_cnt_reg       <= '0;
            scan_pend_reg      <= 1'b0;
            best_val_reg       <= '0;
            best_cnt_reg       <= '0;
            full_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
            window_full_reg    <= 1'b0;
            mode_value_reg     <= '0;
            mode_count_reg     <= '0;
            running_sum_reg    <= '0;
        end
        else
        begin
            cnt_rd_idx_reg <= cnt_raddr;

            // result taken with no new one loading behind it
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            // count table write sets the entry valid
            if (cnt_we)
            begin
                cnt_valid_reg[cnt_rd_idx_reg] <= 1'b1;
            end

            // register write clears the sequence
            if (cfg_wr)
            begin
                window_size_reg    <= pwdata[WS_W-1:0];
                write_position_reg <= '0;
                fill_level_reg     <= '0;
                mode_total_reg     <= '0;
                cnt_valid_reg      <= '0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        sample_reg <= s_in;
                        pos_reg    <= pos_eff;
                        if (start_req)
                        begin
                            fill_level_reg <= '0;
                            mode_total_reg <= '0;
                            cnt_valid_reg  <= '0;
                        end
                        state_reg <= (fill_eff >= win) ? S_RING : S_NEWA;
                    end
                end
                S_RING:
                begin
                    state_reg <= S_OLDA;
                end
                S_OLDA:
                begin
                    state_reg <= S_OLDB;
                end
                S_OLDB:
                begin
                    state_reg <= S_NEWA;
                end
                S_NEWA:
                begin
                    state_reg <= S_NEWB;
                end
                S_NEWB:
                begin
                    write_position_reg <= pos_next;
                    fill_level_reg     <= fill_next;
                    full_reg           <= (fill_next >= win);
                    scan_cnt_reg       <= '0;
                    scan_pend_reg      <= 1'b0;
                    best_val_reg       <= '0;
                    best_cnt_reg       <= '0;
                    state_reg          <= (fill_next >= win) ? S_SCAN : S_OUT;
                end
                S_SCAN:
                begin
                    // strict compare keeps the smallest value on ties
                    if (scan_pend_reg && (cnt_cur > best_cnt_reg))
                    begin
                        best_cnt_reg <= cnt_cur;
                        best_val_reg <= cnt_rd_idx_reg;
                    end
                    scan_pend_reg <= (scan_cnt_reg < SC_W'(NV));
                    if (scan_cnt_reg == SC_W'(NV))
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        scan_cnt_reg <= scan_cnt_reg + SC_W'(1);
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        window_full_reg <= full_reg;
                        if (full_reg)
                        begin
                            mode_value_reg  <= MODE_W'(best_val_reg);
                            mode_count_reg  <= best_cnt_reg;
                            mode_total_reg  <= sum_sat;
                            running_sum_reg <= sum_sat;
                        end
                        else
                        begin
                            mode_value_reg  <= '0;
                            mode_count_reg  <= '0;
                            running_sum_reg <= mode_total_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign out_valid   = out_valid_reg;
    assign window_full = window_full_reg;
    assign mode_value  = mode_value_reg;
    assign mode_count  = mode_count_reg;
    assign running_sum = running_sum_reg;

endmodule : sliding_window_mode_sum_top

`default_nettype wire
